### sv/atm_pkg.sv
// ----------------------------------------------------------------------------
// atm_pkg
// Shared widths, latencies and types for the ACES tone mapper with RGBA8 pack.
// ----------------------------------------------------------------------------
package atm_pkg;

  // Channel as it arrives, and its clamped magnitude
  localparam int unsigned ChanW = 24;
  localparam int unsigned MagW  = ChanW - 1;

  // Curve factors (251x + 3) and (243x + 59), sized for the largest fraction
  localparam int unsigned CoefW = 32;

  // Numerator and denominator products, sized for the largest fraction
  localparam int unsigned ProdW = 56;

  // Partial remainder of 255 * numerator
  localparam int unsigned RemW = ProdW + 8;

  // Result code
  localparam int unsigned CodeW = 8;
  localparam logic [CodeW-1:0] CodeMax = 8'hFF;
  localparam logic [CodeW-1:0] Alpha   = 8'hFF;

  // Lane pipeline: clamp/coefficients, products, saturation/scale, 8 divide steps
  localparam int unsigned DivSteps = CodeW;
  localparam int unsigned LaneLat  = 3 + DivSteps;

  // Stage control that travels from the lanes to the packing stage
  typedef struct packed {
    logic valid;
    logic row_end;
  } atm_ctl_t;

endpackage

### sv/atm_lane.sv
// ----------------------------------------------------------------------------
// atm_lane
// One colour channel: clamp, evaluate the fitted curve and divide it out to
// an 8-bit code through a pipeline of restoring divide steps.
// ----------------------------------------------------------------------------
module atm_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [atm_pkg::ChanW-1:0]      chan_i,
  output logic [atm_pkg::CodeW-1:0]      code_o
);

  localparam logic [atm_pkg::CoefW-1:0] NumOff =
    atm_pkg::CoefW'(3) << FRAC_BITS;
  localparam logic [atm_pkg::CoefW-1:0] DenOff =
    atm_pkg::CoefW'(59) << FRAC_BITS;
  localparam logic [atm_pkg::ProdW-1:0] DenConst =
    atm_pkg::ProdW'(14) << (2 * FRAC_BITS);

  localparam int unsigned PadX = atm_pkg::ProdW - atm_pkg::MagW;
  localparam int unsigned PadC = atm_pkg::ProdW - atm_pkg::CoefW;
  localparam int unsigned PadR = atm_pkg::RemW - atm_pkg::ProdW;

  // Stage 1: clamp and linear factors
  logic [atm_pkg::MagW-1:0]  x_d, x_q;
  logic [atm_pkg::CoefW-1:0] fa_d, fa_q, fb_d, fb_q;

  always_comb begin
    x_d  = chan_i[atm_pkg::ChanW-1] ? '0 : chan_i[atm_pkg::MagW-1:0];
    fa_d = atm_pkg::CoefW'({{(atm_pkg::CoefW-atm_pkg::MagW){1'b0}}, x_d}
                           * atm_pkg::CoefW'(251)) + NumOff;
    fb_d = atm_pkg::CoefW'({{(atm_pkg::CoefW-atm_pkg::MagW){1'b0}}, x_d}
                           * atm_pkg::CoefW'(243)) + DenOff;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      fa_q <= fa_d;
      fb_q <= fb_d;
    end
  end

  // Stage 2: numerator and denominator products
  logic [atm_pkg::ProdW-1:0] num_d, num_q, den_d, den_q;

  always_comb begin
    num_d = {{PadX{1'b0}}, x_q} * {{PadC{1'b0}}, fa_q};
    den_d = ({{PadX{1'b0}}, x_q} * {{PadC{1'b0}}, fb_q}) + DenConst;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  // Stage 3 feeds the divide chain: index 0 is its output
  logic [atm_pkg::RemW-1:0]  rem_q [atm_pkg::DivSteps+1];
  logic [atm_pkg::ProdW-1:0] dvs_q [atm_pkg::DivSteps+1];
  logic [atm_pkg::CodeW-1:0] quo_q [atm_pkg::DivSteps+1];
  logic                      sat_q [atm_pkg::DivSteps+1];

  // Saturate at or above one, otherwise scale the numerator by 255
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= (num_q >= den_q);
      rem_q[0] <= {num_q, 8'd0} - {{PadR{1'b0}}, num_q};
      dvs_q[0] <= den_q;
      quo_q[0] <= '0;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < atm_pkg::DivSteps; k++) begin : g_div
    localparam int unsigned Sh = atm_pkg::DivSteps - 1 - k;

    logic [atm_pkg::RemW-1:0] trial;
    logic                     take;
    logic [atm_pkg::RemW-1:0] rem_d;
    logic [atm_pkg::CodeW-1:0] quo_d;

    always_comb begin
      trial = {{PadR{1'b0}}, dvs_q[k]} << Sh;
      take  = (rem_q[k] >= trial);
      rem_d = take ? (rem_q[k] - trial) : rem_q[k];
      quo_d = {quo_q[k][atm_pkg::CodeW-2:0], take};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        dvs_q[k+1] <= dvs_q[k];
        quo_q[k+1] <= quo_d;
        sat_q[k+1] <= sat_q[k];
      end
    end
  end

  assign code_o = sat_q[atm_pkg::DivSteps] ? atm_pkg::CodeMax : quo_q[atm_pkg::DivSteps];

endmodule

### sv/atm_pack.sv
// ----------------------------------------------------------------------------
// atm_pack
// Merge the three lane codes with alpha into one RGBA word, behind an output
// register and a skid register that decouple the pipeline from the receiver.
// ----------------------------------------------------------------------------
module atm_pack (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  atm_pkg::atm_ctl_t         ctl_i,
  input  logic [atm_pkg::CodeW-1:0] red_i,
  input  logic [atm_pkg::CodeW-1:0] green_i,
  input  logic [atm_pkg::CodeW-1:0] blue_i,
  input  logic                      out_stall_i,
  output logic                      en_o,
  output logic                      out_valid_o,
  output logic [31:0]               rgba_o,
  output logic                      row_end_out_o
);

  logic        out_vq, out_vd;
  logic        skid_vq, skid_vd;
  logic [31:0] out_word_q, out_word_d, skid_word_q, skid_word_d;
  logic        out_re_q, out_re_d, skid_re_q, skid_re_d;
  logic [31:0] word;
  logic        arrive;

  // Advance the pipeline while the skid register is free
  assign en_o   = !skid_vq;
  assign arrive = en_o && ctl_i.valid;
  assign word   = {atm_pkg::Alpha, blue_i, green_i, red_i};

  // Fill the output word first, park in the skid register when stalled
  always_comb begin
    out_vd      = out_vq;
    out_word_d  = out_word_q;
    out_re_d    = out_re_q;
    skid_vd     = skid_vq;
    skid_word_d = skid_word_q;
    skid_re_d   = skid_re_q;
    if (!out_vq || !out_stall_i) begin
      if (skid_vq) begin
        out_vd     = 1'b1;
        out_word_d = skid_word_q;
        out_re_d   = skid_re_q;
      end else begin
        out_vd     = arrive;
        out_word_d = word;
        out_re_d   = ctl_i.row_end;
      end
      skid_vd = 1'b0;
    end else if (arrive) begin
      skid_vd     = 1'b1;
      skid_word_d = word;
      skid_re_d   = ctl_i.row_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq  <= 1'b0;
      skid_vq <= 1'b0;
    end else begin
      out_vq  <= out_vd;
      skid_vq <= skid_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    out_re_q    <= out_re_d;
    skid_word_q <= skid_word_d;
    skid_re_q   <= skid_re_d;
  end

  assign out_valid_o   = out_vq;
  assign rgba_o        = out_word_q;
  assign row_end_out_o = out_re_q;

endmodule

### sv/aces_tonemap_rgba8_pack.sv
// ----------------------------------------------------------------------------
// aces_tonemap_rgba8_pack
// Filmic tone mapper: three HDR channels in, one packed RGBA8 word out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with red_i, green_i, blue_i (signed
// fixed point, FRAC_BITS fraction bits) and row_end_i. A word is taken at a
// rising edge with in_valid_i high and in_stall_o low.
// Output channel: out_valid_o / out_stall_i with rgba_o (red in bits 7:0,
// green 15:8, blue 23:16, alpha 255 in 31:24) and row_end_out_o.
// Throughput: one word per clock while in_stall_o is low. Three channel lanes
// run side by side, each a pipeline of clamp and factors, products, saturate
// and scale, then eight restoring divide steps of one quotient bit each.
// Path: a word passes the 11 lane registers, the first loaded at the accepting
// edge, then the output register, before out_valid_o rises.
// Stall: an output register and a skid register sit behind the lanes; when the
// receiver stalls, one more word drains into the skid register, then
// in_stall_o rises and the lanes hold until the skid register empties.
// Reset: clears all valid flags; no word is in flight afterwards.
// ----------------------------------------------------------------------------
module aces_tonemap_rgba8_pack #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [23:0]        red_i,
  input  logic signed [23:0]        green_i,
  input  logic signed [23:0]        blue_i,
  input  logic                      row_end_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [31:0]               rgba_o,
  output logic                      row_end_out_o
);

  logic                      en;
  logic [atm_pkg::CodeW-1:0] code_r, code_g, code_b;
  logic                      vld_q [atm_pkg::LaneLat];
  logic                      re_q  [atm_pkg::LaneLat];
  atm_pkg::atm_ctl_t         ctl;

  assign in_stall_o = !en;

  // Colour lanes
  atm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_r (
    .clk_i (clk_i), .en_i (en), .chan_i (red_i),   .code_o (code_r)
  );
  atm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_g (
    .clk_i (clk_i), .en_i (en), .chan_i (green_i), .code_o (code_g)
  );
  atm_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_b (
    .clk_i (clk_i), .en_i (en), .chan_i (blue_i),  .code_o (code_b)
  );

  // Track word valid alongside the lanes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < atm_pkg::LaneLat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < atm_pkg::LaneLat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  // Carry the end-of-row mark alongside the lanes
  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q[0] <= row_end_i;
      for (int i = 1; i < atm_pkg::LaneLat; i++) re_q[i] <= re_q[i-1];
    end
  end

  assign ctl.valid   = vld_q[atm_pkg::LaneLat-1];
  assign ctl.row_end = re_q[atm_pkg::LaneLat-1];

  // Merge lane codes and drive the output channel
  atm_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .red_i         (code_r),
    .green_i       (code_g),
    .blue_i        (code_b),
    .out_stall_i   (out_stall_i),
    .en_o          (en),
    .out_valid_o   (out_valid_o),
    .rgba_o        (rgba_o),
    .row_end_out_o (row_end_out_o)
  );

  // A full skid register implies a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("skid register holds a word while output is empty");

  // Input back-pressure only starts after the receiver held a valid word
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output back-pressure");

  // Alpha byte is constant on every presented word
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (rgba_o[31:24] == atm_pkg::Alpha))
    else $error("alpha byte corrupted");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ACES filmic tone mapper with RGBA8 packing.
// A directed table covers the channel extremes, negative clamping, saturation
// and the knee of the curve. Random pixels follow, with random gaps on the
// sending side and random stalls on the receiving side. Every packed word
// that leaves the block is checked against the table or an exact integer model.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned Frac   = 16;
  localparam int unsigned DirN   = 20;
  localparam int unsigned RandN  = 1600;
  localparam int unsigned TotalN = DirN + RandN;
  localparam int unsigned Limit  = 400_000;

  // One directed pixel; rgba is only meaningful where known is set
  typedef struct packed {
    logic signed [23:0] red;
    logic signed [23:0] green;
    logic signed [23:0] blue;
    logic               row_end;
    logic               known;
    logic [31:0]        rgba;
  } pix_row_t;

  // One expected packed word
  typedef struct packed {
    logic [31:0] rgba;
    logic        row_end;
  } pix_res_t;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic signed [23:0] red         = '0;
  logic signed [23:0] green       = '0;
  logic signed [23:0] blue        = '0;
  logic               row_end     = 1'b0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [31:0]        rgba;
  logic               row_end_out;

  pix_res_t    pending_px [$];
  pix_res_t    want_px;
  bit          calm;
  int unsigned cycles;
  int unsigned errs;
  int unsigned checked;
  int unsigned rows_seen;
  int unsigned zero_codes;
  int unsigned full_codes;
  int unsigned mid_codes;
  int          ch;

  // Directed pixels: extremes, clamping, saturation and the curve's knee
  pix_row_t dir_tab [DirN] = '{
    '{0, 0, 0, 1'b0, 1'b1, 32'hFF00_0000},
    '{-1, -1, -1, 1'b1, 1'b1, 32'hFF00_0000},
    '{-8388608, -8388608, -8388608, 1'b0, 1'b1, 32'hFF00_0000},
    '{8388607, 8388607, 8388607, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{8388607, 0, -8388608, 1'b0, 1'b1, 32'hFF00_00FF},
    '{-8388608, 8388607, 0, 1'b1, 1'b1, 32'hFF00_FF00},
    '{0, -8388608, 8388607, 1'b0, 1'b1, 32'hFFFF_0000},
    '{1, 1, 1, 1'b0, 1'b0, 32'h0},
    '{65536, 32768, 131072, 1'b1, 1'b0, 32'h0},
    '{474000, 474600, 475200, 1'b0, 1'b0, 32'h0},
    '{474500, 474700, 474650, 1'b1, 1'b0, 32'h0},
    '{24'h400000, 24'h100000, 24'h080000, 1'b0, 1'b1, 32'hFFFF_FFFF},
    '{256, 4096, 16384, 1'b0, 1'b0, 32'h0},
    '{-65536, 65536, -32768, 1'b1, 1'b0, 32'h0},
    '{200000, 300000, 400000, 1'b0, 1'b0, 32'h0},
    '{8388607, -8388608, 1, 1'b1, 1'b0, 32'h0},
    '{24'h555555, 24'h2AAAAA, 24'h7FFFFF, 1'b0, 1'b0, 32'h0},
    '{13107, 6553, 100, 1'b1, 1'b0, 32'h0},
    '{1, -2, 24'h7FFFFE, 1'b0, 1'b0, 32'h0},
    '{19660, 45875, 98304, 1'b1, 1'b0, 32'h0}
  };

  aces_tonemap_rgba8_pack #(
    .FRAC_BITS(Frac)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .row_end_i    (row_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .rgba_o       (rgba),
    .row_end_out_o(row_end_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Exact curve: floor(255 * N / D) with N and D scaled to integers
  function automatic logic [atm_pkg::CodeW-1:0] filmic_code(logic signed [23:0] chan);
    bit [79:0] x;
    bit [79:0] unit;
    bit [79:0] num;
    bit [79:0] den;
    bit [79:0] q;
    if (chan < 0) return '0;
    x    = {57'd0, chan[22:0]};
    unit = 80'd1 << Frac;
    num  = x * (251 * x + 3 * unit);
    den  = x * (243 * x + 59 * unit) + 14 * unit * unit;
    if (num >= den) return atm_pkg::CodeMax;
    q = (255 * num) / den;
    return q[atm_pkg::CodeW-1:0];
  endfunction

  function automatic logic [31:0] packed_pixel(logic signed [23:0] r, logic signed [23:0] g,
                                               logic signed [23:0] b);
    return {atm_pkg::Alpha, filmic_code(b), filmic_code(g), filmic_code(r)};
  endfunction

  // Random channel, weighted towards the shoulder of the curve
  function automatic logic [23:0] hdr_chan();
    logic [23:0] pick;
    case ($urandom_range(0, 9))
      0, 1: pick = 24'($urandom());
      2, 3, 4, 5: pick = 24'($urandom_range(0, 24'h080000));
      6: pick = 24'(472600 + $urandom_range(0, 4000));
      7: pick = 24'(-int'($urandom_range(1, 8388608)));
      8: pick = 24'($urandom_range(0, 64));
      default: begin
        case ($urandom_range(0, 4))
          0: pick = 24'h000000;
          1: pick = 24'h000001;
          2: pick = 24'h7FFFFF;
          3: pick = 24'h800000;
          default: pick = 24'hFFFFFF;
        endcase
      end
    endcase
    return pick;
  endfunction

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errs++;
    if (errs <= 10)
      $display("mismatch on word %0d, %s: expected %h, got %h", checked, what, want, got);
  endtask

  // Count cycles and end the run if it hangs
  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin
    wait (cycles >= Limit);
    $display("timeout after %0d cycles, %0d words still expected", cycles, pending_px.size());
    $display("FAIL");
    $finish;
  end

  // Receiver: hold stall for a random number of cycles before each word
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  // Check each word that leaves the block against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_px.size() == 0) begin
        note_mismatch("unexpected word", 32'h0, rgba);
      end else begin
        want_px = pending_px.pop_front();
        if (rgba !== want_px.rgba) note_mismatch("rgba", want_px.rgba, rgba);
        if (row_end_out !== want_px.row_end)
          note_mismatch("row_end", {31'd0, want_px.row_end}, {31'd0, row_end_out});
        if (want_px.row_end) rows_seen++;
        for (ch = 0; ch < 3; ch++) begin
          if (want_px.rgba[8*ch +: 8] == 8'd0) zero_codes++;
          else if (want_px.rgba[8*ch +: 8] == atm_pkg::CodeMax) full_codes++;
          else mid_codes++;
        end
      end
      checked++;
    end
  end

  // Sender: reset, directed table, then random pixels; drain and report
  initial begin
    int unsigned gap;
    logic [23:0] r;
    logic [23:0] g;
    logic [23:0] b;
    logic        re;
    pix_res_t    exp_px;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned idx = 0; idx < TotalN; idx++) begin
      if (idx % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      if (idx < DirN) begin
        r  = dir_tab[idx].red;
        g  = dir_tab[idx].green;
        b  = dir_tab[idx].blue;
        re = dir_tab[idx].row_end;
      end else begin
        r  = hdr_chan();
        g  = hdr_chan();
        b  = hdr_chan();
        re = ($urandom_range(0, 7) == 0);
      end
      in_valid <= 1'b1;
      red      <= r;
      green    <= g;
      blue     <= b;
      row_end  <= re;
      // Hold the word until the block takes it
      do @(posedge clk_i); while (in_stall);
      if (idx < DirN && dir_tab[idx].known) exp_px.rgba = dir_tab[idx].rgba;
      else exp_px.rgba = packed_pixel(r, g, b);
      exp_px.row_end = re;
      pending_px.push_back(exp_px);
    end
    in_valid <= 1'b0;

    // Drain, then watch for stray words
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (atm_pkg::LaneLat + 8) @(posedge clk_i);

    $display("sent %0d pixels (%0d directed), checked %0d words, %0d row ends",
             TotalN, DirN, checked, rows_seen);
    $display("channel codes: %0d zero, %0d full scale, %0d in between, %0d errors",
             zero_codes, full_codes, mid_codes, errs);
    if (errs == 0 && pending_px.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
